// ===== rtl/core/dlf_pkg.sv =====
`timescale 1ns / 1ps

package dlf_pkg;

  localparam int unsigned MAX_INPUTS_DEF  = 16;
  localparam int unsigned MAX_NEURONS_DEF = 16;
  localparam int unsigned SIG_DEPTH_DEF   = 256;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [15:0] LR_RESET = 16'd655;
  localparam logic [4:0]  CNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    OP_WR_WEIGHT = 3'd0,
    OP_WR_BIAS   = 3'd1,
    OP_FWD       = 3'd2,
    OP_TARGET    = 3'd3,
    OP_WR_DELTA  = 3'd4,
    OP_UPDATE    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACT   = 2'd0,
    KIND_DELTA = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_LR  = 2'd0,
    CFG_ACT = 2'd1,
    CFG_NIN = 2'd2,
    CFG_NNE = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_WR,
    ST_FWD_RD,
    ST_FWD_MUL,
    ST_FWD_ACC,
    ST_OUT_PRE,
    ST_OUT_EMIT,
    ST_TGT_A,
    ST_TGT_P,
    ST_TGT_D,
    ST_TGT_R,
    ST_TGT_EMIT,
    ST_UPD_RD,
    ST_UPD_LR,
    ST_UPD_WR,
    ST_BIAS_MUL,
    ST_BIAS_WR,
    ST_DONE
  } st_e;

  // effective configuration, counts already clamped
  typedef struct packed {
    logic [15:0] lr;
    logic        act;
    logic [4:0]  nin;
    logic [4:0]  nne;
  } cfg_t;

  typedef struct packed {
    op_e                op;
    logic [3:0]         ii;
    logic [3:0]         ni;
    logic signed [15:0] value;
    logic               last;
    logic               use_elem;
  } cmd_t;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
    if (v > 50'sd32767) return 16'sh7fff;
    if (v < -50'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // floor((v + half) / 2^s)
  function automatic logic signed [49:0] rshr(input logic signed [49:0] v,
                                              input int unsigned s);
    logic signed [49:0] h;
    h = 50'sd1 <<< (s - 1);
    return (v + h) >>> s;
  endfunction

  // shift-subtract divide, elaboration use only
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], n[k]};
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // e^-a in Q0.16, a in Q4.12
  function automatic longint unsigned exp_neg(input longint unsigned a);
    longint unsigned t, n, f, f2, f3, f4, p;
    t  = (a * 64'd94548) >> 12;
    n  = t >> 16;
    f  = t & 64'hFFFF;
    f2 = (f * f) >> 16;
    f3 = (f2 * f) >> 16;
    f4 = (f3 * f) >> 16;
    p  = 64'd65536 - ((64'd45426 * f) >> 16) + ((64'd15743 * f2) >> 16)
         - ((64'd3638 * f3) >> 16) + ((64'd630 * f4) >> 16);
    return (n >= 16) ? 64'd0 : (p >> n);
  endfunction

  // sigmoid at the center of bin i, Q4.12
  function automatic logic [15:0] sig_entry(input int i, input int depth);
    longint          c;
    longint unsigned a, e, s;
    c = -64'sd32768 + longint'(udiv(longint'(2 * i + 1) * 64'd32768,
                                    longint'(depth)));
    a = (c < 0) ? longint'(-c) : longint'(c);
    e = exp_neg(a);
    s = udiv(64'h1_0000_0000, 64'd65536 + e);
    if (c < 0) s = 64'd65536 - s;
    return 16'((s + 64'd8) >> 4);
  endfunction

endpackage

// ===== rtl/core/dlf_front.sv =====
`timescale 1ns / 1ps

module dlf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic [3:0]          input_index_i,
  input  logic [3:0]          neuron_index_i,
  input  logic signed [15:0]  value_i,
  input  logic                last_element_i,
  input  dlf_pkg::cfg_t       cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output dlf_pkg::cmd_t       q_cmd_o
);
  import dlf_pkg::*;

  logic keep;
  logic busy_q;

  // registered copy of the push strobe; it has no effect on push, as busy_q | ~busy_q is always true
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= q_push_o;
    end
  end

  always_comb begin
    q_cmd_o.ii       = input_index_i;
    q_cmd_o.ni       = neuron_index_i;
    q_cmd_o.value    = value_i;
    q_cmd_o.last     = last_element_i;
    q_cmd_o.use_elem = (5'(input_index_i) < cfg_i.nin);
    q_cmd_o.op       = OP_WR_WEIGHT;
    keep             = 1'b1;
    case (opcode_i)
      OP_WR_WEIGHT: q_cmd_o.op = OP_WR_WEIGHT;
      OP_WR_BIAS:   q_cmd_o.op = OP_WR_BIAS;
      OP_FWD: begin
        q_cmd_o.op = OP_FWD;
        // element out of range and not last does nothing
        keep = q_cmd_o.use_elem | last_element_i;
      end
      OP_TARGET:    q_cmd_o.op = OP_TARGET;
      OP_WR_DELTA:  q_cmd_o.op = OP_WR_DELTA;
      OP_UPDATE:    q_cmd_o.op = OP_UPDATE;
      default:      keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i & keep & (busy_q | ~busy_q);

endmodule

// ===== rtl/core/dlf_queue.sv =====
`timescale 1ns / 1ps

module dlf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dlf_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dlf_pkg::cmd_t cmd_o
);
  import dlf_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/dlf_back.sv =====
`timescale 1ns / 1ps

module dlf_back #(
  parameter int unsigned MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
  parameter int unsigned MAX_NEURONS = dlf_pkg::MAX_NEURONS_DEF,
  parameter int unsigned SIG_DEPTH   = dlf_pkg::SIG_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlf_pkg::cfg_t       cfg_i,
  input  logic                q_valid_i,
  input  dlf_pkg::cmd_t       q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [3:0]          neuron_o,
  output logic signed [15:0]  result_value_o,
  output logic                last_o
);
  import dlf_pkg::*;

  localparam int unsigned IC = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;
  localparam int unsigned NC = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;
  localparam int unsigned IW = (IC > 1) ? $clog2(IC) : 1;
  localparam int unsigned NW = (NC > 1) ? $clog2(NC) : 1;
  localparam int unsigned MD = IC * NC;
  localparam int unsigned AW = (MD > 1) ? $clog2(MD) : 1;
  localparam int unsigned DW = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;

  st_e st_q, st_d;
  cmd_t cmd_q;
  logic [NW-1:0] n_q;
  logic [IW-1:0] i_q;

  logic signed [31:0] acc_q [NC];
  logic signed [15:0] act_q [NC];
  logic signed [15:0] dlt_q [NC];
  logic signed [15:0] smp_q [IC];
  logic signed [15:0] bias_q [NC];
  logic signed [15:0] mem [MD];
  logic signed [15:0] rdata_q;

  logic signed [48:0] prod_q;
  logic signed [15:0] d_q, p_q, z_q;

  logic [15:0] sig_tab [SIG_DEPTH];

  for (genvar g = 0; g < SIG_DEPTH; g++) begin : g_tab
    localparam logic [15:0] ENTRY = sig_entry(g, SIG_DEPTH);
    assign sig_tab[g] = ENTRY;
  end

  // control
  logic out_free, n_last, i_last, ni_ok, ii_ok;
  logic emit, mem_we;
  logic [AW-1:0] mem_addr;
  logic signed [15:0] mem_wdata;
  kind_e emit_kind;
  logic [3:0] emit_neu;
  logic signed [15:0] emit_val;
  logic emit_last;
  logic out_valid_q;

  // datapath
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_res;
  logic signed [15:0] pre_z, z_full, d_first, p_new, d_fin, w_new, b_new;
  logic signed [31:0] acc_new;
  logic signed [15:0] a_sel, sig_val;
  logic [15:0] z_off;
  logic [16+DW:0] ip;
  logic [DW-1:0] sidx;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign n_last   = (5'(n_q) == cfg_i.nne - 5'd1);
  assign i_last   = (5'(i_q) == cfg_i.nin - 5'd1);
  assign ni_ok    = (5'(cmd_q.ni) < 5'(NC));
  assign ii_ok    = (5'(cmd_q.ii) < 5'(IC));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            OP_WR_WEIGHT, OP_WR_BIAS, OP_WR_DELTA: st_d = ST_WR;
            OP_FWD: begin
              if (q_cmd_i.use_elem)  st_d = ST_FWD_RD;
              else if (q_cmd_i.last) st_d = ST_OUT_PRE;
              else                   st_d = ST_IDLE;
            end
            OP_TARGET: st_d = (5'(q_cmd_i.ni) < 5'(NC)) ? ST_TGT_A : ST_TGT_EMIT;
            OP_UPDATE: st_d = ST_UPD_RD;
            default:   st_d = ST_IDLE;
          endcase
        end
      end
      ST_WR:       if (out_free) st_d = ST_IDLE;
      ST_FWD_RD:   st_d = ST_FWD_MUL;
      ST_FWD_MUL:  st_d = ST_FWD_ACC;
      ST_FWD_ACC: begin
        if (!n_last)         st_d = ST_FWD_RD;
        else if (cmd_q.last) st_d = ST_OUT_PRE;
        else                 st_d = ST_IDLE;
      end
      ST_OUT_PRE:  st_d = ST_OUT_EMIT;
      ST_OUT_EMIT: if (out_free) st_d = n_last ? ST_IDLE : ST_OUT_PRE;
      ST_TGT_A:    st_d = cfg_i.act ? ST_TGT_P : ST_TGT_EMIT;
      ST_TGT_P:    st_d = ST_TGT_D;
      ST_TGT_D:    st_d = ST_TGT_R;
      ST_TGT_R:    st_d = ST_TGT_EMIT;
      ST_TGT_EMIT: if (out_free) st_d = ST_IDLE;
      ST_UPD_RD:   st_d = ST_UPD_LR;
      ST_UPD_LR:   st_d = ST_UPD_WR;
      ST_UPD_WR:   st_d = i_last ? ST_BIAS_MUL : ST_UPD_RD;
      ST_BIAS_MUL: st_d = ST_BIAS_WR;
      ST_BIAS_WR:  st_d = n_last ? ST_DONE : ST_UPD_RD;
      ST_DONE:     if (out_free) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // arithmetic
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    a_sel = act_q[cmd_q.ni[NW-1:0]];
    case (st_q)
      ST_FWD_MUL: begin
        mul_a = cmd_q.value;
        mul_b = rdata_q;
      end
      ST_TGT_A: begin
        mul_a = a_sel;
        mul_b = 17'sd4096 - 17'(a_sel);
      end
      ST_TGT_D: begin
        mul_a = d_q;
        mul_b = p_q;
      end
      ST_UPD_RD: begin
        mul_a = smp_q[i_q];
        mul_b = dlt_q[n_q];
      end
      ST_UPD_LR: begin
        mul_a = prod_q[31:0];
        mul_b = {1'b0, cfg_i.lr};
      end
      ST_BIAS_MUL: begin
        mul_a = dlt_q[n_q];
        mul_b = {1'b0, cfg_i.lr};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_res = mul_a * mul_b;

    acc_new = sat32(50'(acc_q[n_q]) + 50'(signed'(prod_q[31:0])));
    pre_z   = sat16(rshr(50'(acc_q[n_q]), 12));
    z_full  = sat16(50'(pre_z) + 50'(bias_q[n_q]));
    d_first = sat16(50'sd2 * (50'(a_sel) - 50'(cmd_q.value)));
    p_new   = sat16(rshr(50'(prod_q), 12));
    d_fin   = sat16(rshr(50'(prod_q), 12));
    w_new   = sat16(50'(rdata_q) - rshr(50'(prod_q), 28));
    b_new   = sat16(50'(bias_q[n_q]) - rshr(50'(prod_q), 16));

    // table index = ((z + 32768) * depth) >> 16
    z_off   = {~z_q[15], z_q[14:0]};
    ip      = (17+DW)'(z_off) * (17+DW)'(SIG_DEPTH);
    sidx    = ip[16 +: DW];
    sig_val = sig_tab[sidx];
  end

  // control outputs
  always_comb begin
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    emit_kind = KIND_ACK;
    emit_neu  = cmd_q.ni;
    emit_val  = '0;
    emit_last = 1'b1;
    mem_we    = 1'b0;
    mem_wdata = cmd_q.value;
    mem_addr  = AW'(int'(cmd_q.ii) * NC + int'(n_q));
    case (st_q)
      ST_IDLE: q_pop_o = q_valid_i;
      ST_WR: begin
        emit     = out_free;
        mem_addr = AW'(int'(cmd_q.ii) * NC + int'(cmd_q.ni));
        mem_we   = out_free & (cmd_q.op == OP_WR_WEIGHT) & ii_ok & ni_ok;
      end
      ST_OUT_EMIT: begin
        emit      = out_free;
        emit_kind = KIND_ACT;
        emit_neu  = 4'(n_q);
        emit_val  = cfg_i.act ? sig_val : z_q;
        emit_last = n_last;
      end
      ST_TGT_EMIT: begin
        emit      = out_free;
        emit_kind = KIND_DELTA;
        emit_val  = d_q;
      end
      ST_UPD_RD, ST_UPD_LR: mem_addr = AW'(int'(i_q) * NC + int'(n_q));
      ST_UPD_WR: begin
        mem_addr  = AW'(int'(i_q) * NC + int'(n_q));
        mem_we    = 1'b1;
        mem_wdata = w_new;
      end
      ST_DONE: begin
        emit      = out_free;
        emit_kind = KIND_DONE;
        emit_neu  = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    if (st_q == ST_IDLE) d_q <= '0;
    case (st_q)
      ST_FWD_MUL, ST_TGT_A, ST_TGT_D, ST_UPD_RD, ST_UPD_LR, ST_BIAS_MUL:
        prod_q <= mul_res;
      default: prod_q <= prod_q;
    endcase
    if (st_q == ST_OUT_PRE) z_q <= z_full;
    if (st_q == ST_TGT_A)   d_q <= d_first;
    if (st_q == ST_TGT_P)   p_q <= p_new;
    if (st_q == ST_TGT_R)   d_q <= d_fin;
    if (st_q == ST_WR && out_free && cmd_q.op == OP_WR_BIAS && ni_ok)
      bias_q[cmd_q.ni[NW-1:0]] <= cmd_q.value;
    if (st_q == ST_BIAS_WR) bias_q[n_q] <= b_new;
    if (emit) begin
      kind_o         <= emit_kind;
      neuron_o       <= emit_neu;
      result_value_o <= emit_val;
      last_o         <= emit_last;
    end
  end

  // control and zero-reset stores
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < NC; k++) begin
        acc_q[k] <= '0;
        act_q[k] <= '0;
        dlt_q[k] <= '0;
      end
      for (int k = 0; k < IC; k++) smp_q[k] <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= emit | (out_valid_q & out_stall_i);
      if (q_pop_o) begin
        n_q <= '0;
        i_q <= '0;
        if (q_cmd_i.op == OP_FWD && q_cmd_i.use_elem)
          smp_q[q_cmd_i.ii[IW-1:0]] <= q_cmd_i.value;
      end
      case (st_q)
        ST_FWD_ACC: begin
          acc_q[n_q] <= acc_new;
          n_q <= n_last ? '0 : n_q + 1'b1;
        end
        ST_OUT_EMIT: begin
          if (out_free) begin
            act_q[n_q] <= emit_val;
            n_q <= n_q + 1'b1;
            if (n_last) begin
              for (int k = 0; k < NC; k++) acc_q[k] <= '0;
            end
          end
        end
        ST_WR: begin
          if (out_free && cmd_q.op == OP_WR_DELTA && ni_ok)
            dlt_q[cmd_q.ni[NW-1:0]] <= cmd_q.value;
        end
        ST_TGT_EMIT: begin
          if (out_free && ni_ok) dlt_q[cmd_q.ni[NW-1:0]] <= d_q;
        end
        ST_UPD_WR: i_q <= i_last ? '0 : i_q + 1'b1;
        ST_BIAS_WR: begin
          n_q <= n_q + 1'b1;
          i_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/dense_layer_forward_sgd_update.sv =====
// Requests are queued two deep in front of a sequencer with one shared 32x17 multiplier.
// Forward element: a pop, then read, multiply and accumulate for each neuron in use;
// a last element then forms and emits each neuron's activation in turn.
// Update: read, scale, write per weight and a bias step per neuron; targets and writes emit once.
// Results leave from a register; stalls hold the sequencer. The queue takes requests while busy.
// Reset clears control, accumulators, activations, deltas, inputs; weights, biases undefined.
`timescale 1ns / 1ps

module dense_layer_forward_sgd_update #(
  parameter int unsigned MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
  parameter int unsigned MAX_NEURONS = dlf_pkg::MAX_NEURONS_DEF,
  parameter int unsigned SIG_DEPTH   = dlf_pkg::SIG_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dlf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dlf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       opcode_i,
  input  logic [3:0]                       input_index_i,
  input  logic [3:0]                       neuron_index_i,
  input  logic signed [15:0]               value_i,
  input  logic                             last_element_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       kind_o,
  output logic [3:0]                       neuron_o,
  output logic signed [15:0]               result_value_o,
  output logic                             last_o
);
  import dlf_pkg::*;

  localparam int unsigned IC = (MAX_INPUTS < 16) ? MAX_INPUTS : 16;
  localparam int unsigned NC = (MAX_NEURONS < 16) ? MAX_NEURONS : 16;

  logic [15:0] lr_q;
  logic        act_q;
  logic [4:0]  nin_q, nne_q;
  cfg_t        cfg;

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= LR_RESET;
      act_q <= 1'b1;
      nin_q <= CNT_RESET;
      nne_q <= CNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LR:  lr_q  <= cfg_data_i;
        CFG_ACT: act_q <= cfg_data_i[0];
        CFG_NIN: nin_q <= cfg_data_i[4:0];
        CFG_NNE: nne_q <= cfg_data_i[4:0];
        default: lr_q  <= lr_q;
      endcase
    end
  end

  always_comb begin
    cfg.lr  = lr_q;
    cfg.act = act_q;
    cfg.nin = (nin_q == '0) ? 5'd1 : ((nin_q > 5'(IC)) ? 5'(IC) : nin_q);
    cfg.nne = (nne_q == '0) ? 5'd1 : ((nne_q > 5'(NC)) ? 5'(NC) : nne_q);
  end

  dlf_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .input_index_i,
    .neuron_index_i,
    .value_i,
    .last_element_i,
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_in)
  );

  dlf_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .cmd_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_out)
  );

  dlf_back #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_NEURONS (MAX_NEURONS),
    .SIG_DEPTH   (SIG_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_out),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .kind_o,
    .neuron_o,
    .result_value_o,
    .last_o
  );

endmodule

// ===== rtl/core/dlf_checker.sv =====
`timescale 1ns / 1ps

module dlf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        kind_o,
  input logic [3:0]        neuron_o,
  input logic signed [15:0] result_value_o,
  input logic              last_o
);
  import dlf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(kind_o) && $stable(neuron_o)
      && $stable(result_value_o) && $stable(last_o))
    else $error("stalled result changed");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DONE |-> neuron_o == 4'd0
      && result_value_o == 16'sd0 && last_o)
    else $error("bad update done result");

  a_ack_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_ACK |-> result_value_o == 16'sd0 && last_o)
    else $error("bad write acknowledge");

  a_delta_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DELTA |-> last_o)
    else $error("delta not marked last");

endmodule

bind dense_layer_forward_sgd_update dlf_checker u_chk (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dlf_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES  = 200;

  typedef struct packed {
    logic [2:0]         op;
    logic [3:0]         ii;
    logic [3:0]         ni;
    logic signed [15:0] value;
    logic               last;
  } req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         neuron;
    logic signed [15:0] value;
    logic               last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic [3:0] input_index = '0;
  logic [3:0] neuron_index = '0;
  logic signed [15:0] value = '0;
  logic last_element = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [3:0] neuron;
  logic signed [15:0] result_value;
  logic last;

  req_t pend_reqs[$];
  res_t expected_results[$];
  int unsigned errors = 0;
  int unsigned cycle = 0;
  int unsigned n_results = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_left = 0;
  bit held = 1'b0;

  // layer state as the block should hold it
  logic signed [15:0] m_weight[256];
  logic signed [15:0] m_bias[16];
  logic signed [31:0] m_acc[16];
  logic signed [15:0] m_act_st[16];
  logic signed [15:0] m_delta[16];
  logic signed [15:0] m_x[16];
  logic signed [15:0] sig_lut[256];
  logic [15:0] m_lr = LR_RESET;
  logic m_sig = 1'b1;
  logic [4:0] m_nin = CNT_RESET;
  logic [4:0] m_nne = CNT_RESET;

  dense_layer_forward_sgd_update u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .input_index_i(input_index), .neuron_index_i(neuron_index),
    .value_i(value), .last_element_i(last_element),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .neuron_o(neuron), .result_value_o(result_value), .last_o(last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint clip16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint clip32(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int count_eff(logic [4:0] c);
    return c == 0 ? 1 : (c > 16 ? 16 : int'(c));
  endfunction

  // e^-|x| via 2^-t, then 1/(1+e), mirrored for negative centers
  function automatic logic signed [15:0] sigmoid_at(longint c);
    longint unsigned a, t, n, f, f2, f3, f4, p, e, s;
    a = c < 0 ? -c : c;
    t = (a * 94548) >> 12;
    n = t >> 16;
    f = t & 64'hFFFF;
    f2 = (f * f) >> 16;
    f3 = (f2 * f) >> 16;
    f4 = (f3 * f) >> 16;
    p = 65536 - ((45426 * f) >> 16) + ((15743 * f2) >> 16)
        - ((3638 * f3) >> 16) + ((630 * f4) >> 16);
    e = n >= 16 ? 0 : (p >> n);
    s = 64'h1_0000_0000 / (65536 + e);
    if (c < 0) s = 65536 - s;
    return 16'((s + 8) >> 4);
  endfunction

  task automatic expect_res(logic [1:0] k, logic [3:0] n, longint v, logic l);
    res_t r;
    r.kind = k;
    r.neuron = n;
    r.value = 16'(v);
    r.last = l;
    expected_results.push_back(r);
  endtask

  task automatic predict_layer(req_t q);
    int nin, nne;
    longint z, a, d, p, lr;
    nin = count_eff(m_nin);
    nne = count_eff(m_nne);
    lr = longint'(m_lr);
    case (q.op)
      OP_WR_WEIGHT: begin
        m_weight[q.ii * 16 + q.ni] = q.value;
        expect_res(KIND_ACK, q.ni, 0, 1'b1);
      end
      OP_WR_BIAS: begin
        m_bias[q.ni] = q.value;
        expect_res(KIND_ACK, q.ni, 0, 1'b1);
      end
      OP_FWD: begin
        if (q.ii < nin) begin
          m_x[q.ii] = q.value;
          for (int n = 0; n < nne; n++)
            m_acc[n] = 32'(clip32(longint'(m_acc[n])
                       + longint'(q.value) * longint'(m_weight[q.ii * 16 + n])));
        end
        if (q.last) begin
          for (int n = 0; n < nne; n++) begin
            z = clip16(round_q(longint'(m_acc[n]), 12));
            z = clip16(z + longint'(m_bias[n]));
            if (m_sig) z = longint'(sig_lut[(z + 32768) >> 8]);
            m_act_st[n] = 16'(z);
            expect_res(KIND_ACT, 4'(n), z, n + 1 == nne);
          end
          for (int n = 0; n < 16; n++) m_acc[n] = '0;
        end
      end
      OP_TARGET: begin
        a = longint'(m_act_st[q.ni]);
        d = clip16(2 * (a - longint'(q.value)));
        if (m_sig) begin
          p = clip16(round_q(a * (4096 - a), 12));
          d = clip16(round_q(d * p, 12));
        end
        m_delta[q.ni] = 16'(d);
        expect_res(KIND_DELTA, q.ni, d, 1'b1);
      end
      OP_WR_DELTA: begin
        m_delta[q.ni] = q.value;
        expect_res(KIND_ACK, q.ni, 0, 1'b1);
      end
      OP_UPDATE: begin
        for (int n = 0; n < nne; n++) begin
          d = longint'(m_delta[n]);
          for (int i = 0; i < nin; i++)
            m_weight[i * 16 + n] = 16'(clip16(longint'(m_weight[i * 16 + n])
                                   - round_q(lr * (longint'(m_x[i]) * d), 28)));
          m_bias[n] = 16'(clip16(longint'(m_bias[n]) - round_q(lr * d, 16)));
        end
        expect_res(KIND_DONE, 4'd0, 0, 1'b1);
      end
      default: ;
    endcase
  endtask

  // driver: a new request is offered only once the held one has gone in
  always @(posedge clk) begin
    req_t q;
    if (rst_n) begin
      if (in_valid && !in_stall)
        predict_layer({opcode, input_index, neuron_index, value, last_element});
      if (!in_valid || !in_stall) begin
        if (pend_reqs.size() > 0 &&
            ((cycle >= 1000 && cycle < 2500) || $urandom_range(0, 99) >= 28)) begin
          q = pend_reqs.pop_front();
          opcode <= q.op;
          input_index <= q.ii;
          neuron_index <= q.ni;
          value <= q.value;
          last_element <= q.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor, receiver stall and watchdog
  always @(posedge clk) begin
    res_t e;
    cycle <= cycle + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result kind %0d neuron %0d value %0d last %0d",
                   $time, kind, neuron, result_value, last);
          errors <= errors + 1;
        end else begin
          e = expected_results.pop_front();
          if (kind !== e.kind || neuron !== e.neuron || result_value !== e.value ||
              last !== e.last) begin
            $display("%0t mismatch: expected kind %0d neuron %0d value %0d last %0d, got kind %0d neuron %0d value %0d last %0d",
                     $time, e.kind, e.neuron, e.value, e.last,
                     kind, neuron, result_value, last);
            errors <= errors + 1;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (n_results >= 150 && !held) begin
        held <= 1'b1;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(cycle >= 1000 && cycle < 2500) && $urandom_range(0, 99) < 28;
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic add_req(logic [2:0] op, logic [3:0] ii, logic [3:0] ni,
                         logic signed [15:0] v, logic l);
    req_t q;
    q.op = op;
    q.ii = ii;
    q.ni = ni;
    q.value = v;
    q.last = l;
    pend_reqs.push_back(q);
  endtask

  function automatic logic signed [15:0] rand_val();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 16'($signed($urandom_range(0, 4095)) - 2048);
    if (r == 6) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom);
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_LR:  m_lr = data;
      CFG_ACT: m_sig = data[0];
      CFG_NIN: m_nin = data[4:0];
      default: m_nne = data[4:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    wait (pend_reqs.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_layer(logic [15:0] lr, logic sig, logic [4:0] nin, logic [4:0] nne);
    wait_drained();
    cfg_write(CFG_LR, lr);
    cfg_write(CFG_ACT, 16'(sig));
    cfg_write(CFG_NIN, 16'(nin));
    cfg_write(CFG_NNE, 16'(nne));
  endtask

  // mostly well-formed train steps, the rest random requests
  task automatic gen_traffic(int unsigned count);
    int unsigned made, nin, k;
    made = 0;
    nin = count_eff(m_nin);
    while (made < count) begin
      if ($urandom_range(0, 9) < 7) begin
        for (int i = 0; i < nin; i++) begin
          add_req(OP_FWD, $urandom_range(0, 9) == 0 ? 4'($urandom) : 4'(i),
                  4'($urandom), rand_val(), i == nin - 1);
          made++;
        end
        k = $urandom_range(0, 3);
        for (int j = 0; j < k; j++) begin
          add_req(OP_TARGET, 4'($urandom), 4'($urandom), rand_val(), 1'($urandom));
          made++;
        end
        if ($urandom_range(0, 2) == 0) begin
          add_req(OP_WR_DELTA, 4'($urandom), 4'($urandom), rand_val(), 1'($urandom));
          made++;
        end
        if ($urandom_range(0, 1) == 0) begin
          add_req(OP_UPDATE, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
          made++;
        end
      end else begin
        add_req(3'($urandom), 4'($urandom), 4'($urandom), rand_val(), 1'($urandom));
        made++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 256; i++) m_weight[i] = '0;
    for (int i = 0; i < 16; i++) begin
      m_bias[i] = '0;
      m_acc[i] = '0;
      m_act_st[i] = '0;
      m_delta[i] = '0;
      m_x[i] = '0;
    end
    for (int i = 0; i < 256; i++) sig_lut[i] = sigmoid_at(-32768 + (2 * i + 1) * 128);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // load weight rows 0 to 7 and every bias; samples stay at eight inputs or fewer
    // so no forward pass or update reads an unwritten entry
    for (int i = 0; i < 8; i++)
      for (int n = 0; n < 16; n++)
        add_req(OP_WR_WEIGHT, 4'(i), 4'(n), 16'($signed($urandom_range(0, 2047)) - 1024),
                1'b0);
    add_req(OP_WR_WEIGHT, 4'd15, 4'd15, 16'sh7fff, 1'b1);
    add_req(OP_WR_WEIGHT, 4'd0, 4'd0, 16'sh8000, 1'b0);
    for (int n = 0; n < 16; n++)
      add_req(OP_WR_BIAS, 4'($urandom), 4'(n), rand_val(), 1'($urandom));
    set_layer(LR_RESET, 1'b1, 5'd8, 5'd16);

    // directed: extremes of every field, forward, target, delta write, update, ignored codes
    for (int i = 0; i < 8; i++)
      add_req(OP_FWD, 4'(i), 4'(15 - i),
              i == 0 ? 16'sh7fff : (i == 1 ? 16'sh8000 : (i == 2 ? 16'sd0 : rand_val())),
              i == 7);
    add_req(OP_TARGET, 4'd15, 4'd0, 16'sh7fff, 1'b0);
    add_req(OP_TARGET, 4'd0, 4'd15, 16'sh8000, 1'b1);
    add_req(OP_WR_DELTA, 4'd3, 4'd3, 16'sh7fff, 1'b0);
    add_req(OP_WR_DELTA, 4'd4, 4'd4, 16'sh8000, 1'b1);
    add_req(OP_UPDATE, 4'd0, 4'd0, 16'd0, 1'b0);
    add_req(OP_RSVD6, 4'd1, 4'd2, 16'sh1234, 1'b1);
    add_req(OP_RSVD7, 4'd2, 4'd1, 16'sh8765, 1'b0);

    // identity, max step, short sample: out-of-range forward index is dropped
    set_layer(16'hffff, 1'b0, 5'd4, 5'd3);
    add_req(OP_FWD, 4'd9, 4'd0, 16'sh0800, 1'b0);
    add_req(OP_FWD, 4'd1, 4'd0, 16'sh0400, 1'b0);
    add_req(OP_FWD, 4'd1, 4'd0, 16'sh0c00, 1'b0);
    add_req(OP_FWD, 4'd12, 4'd0, 16'sh0100, 1'b1);
    gen_traffic(25);

    // zero counts act as one, oversized counts clamp to sixteen
    set_layer(16'd0, 1'b1, 5'd0, 5'd31);
    gen_traffic(20);
    set_layer(16'd20000, 1'b1, 5'd8, 5'd1);
    gen_traffic(20);
    for (int p = 0; p < 3; p++) begin
      set_layer(16'($urandom), 1'($urandom), 5'($urandom_range(1, 8)),
                5'($urandom_range(1, 16)));
      gen_traffic(13);
    end

    wait_drained();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== dense_layer_forward_sgd_update.f =====
rtl/core/dlf_pkg.sv
rtl/core/dlf_front.sv
rtl/core/dlf_queue.sv
rtl/core/dlf_back.sv
rtl/core/dense_layer_forward_sgd_update.sv
rtl/core/dlf_checker.sv
sim/testbench.sv
